// ===== rtl/core/gaussian_orbital_value_gradient_macros.svh =====
// Assertion macros shared by the orbital evaluation RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef GAUSSIAN_ORBITAL_VALUE_GRADIENT_MACROS_SVH
`define GAUSSIAN_ORBITAL_VALUE_GRADIENT_MACROS_SVH

// Same-cycle implication.
`define GOVG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GOVG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/govg_pkg.sv =====
// Types, constants and fixed-point helpers for the orbital evaluator.
// No dependencies.
package govg_pkg;

	localparam int IN_W      = 32;
	localparam int OUT_W     = 48;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 3;
	localparam int MAX_POWER = 4;
	localparam int NPOW      = MAX_POWER + 2;
	localparam int EXP_TERMS     = 9;
	localparam int EXP_SQUARINGS = 6;

	typedef logic signed [63:0] q_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_ORIGIN_Z,
		REG_ZETA,
		REG_AMPLITUDE,
		REG_POWER_X,
		REG_POWER_Y,
		REG_POWER_Z
	} reg_idx_t;

	localparam q_t         SAT_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic [64:0] SAT_W    = 65'h0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] SAT_P = 65'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0] SAT_N = -SAT_P;
	localparam q_t         ONE_Q     = 64'sh0000_0001_0000_0000;
	localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
	localparam q_t         EXP_LIMIT = 64'sh0000_0018_0000_0000;
	localparam q_t         OUT_MAX_Q = 64'sh0000_7FFF_FFFF_FFFF;
	localparam q_t         OUT_MIN_Q = 64'shFFFF_8000_0000_0000;
	localparam logic [63:0] TWO36    = 64'd1 << 36;

	// floor(2^36 / k); exact quotient after one correction step
	localparam logic [36:0] RECIP [0:9] = '{
		37'd0,
		37'(TWO36 / 64'd1), 37'(TWO36 / 64'd2), 37'(TWO36 / 64'd3),
		37'(TWO36 / 64'd4), 37'(TWO36 / 64'd5), 37'(TWO36 / 64'd6),
		37'(TWO36 / 64'd7), 37'(TWO36 / 64'd8), 37'(TWO36 / 64'd9)
	};

	// four 32x32 partial products of a sign-magnitude multiply
	typedef struct packed {
		logic        neg;
		logic [63:0] hh;
		logic [63:0] hl;
		logic [63:0] lh;
		logic [63:0] ll;
	} pp_t;

	typedef struct packed {
		q_t [2:0]            d;
		q_t [2:0][NPOW-1:0]  pw;
		pp_t [3:0]           pp;
		q_t                  r2;
		q_t                  t;
		logic [31:0]         s;
		logic [32:0]         acc;
		logic [31:0]         hp;
		logic                ez;
		q_t                  com;
		q_t [2:0]            fac;
		q_t [2:0]            lo;
		q_t [2:0]            hi;
		q_t [2:0]            br;
		q_t [3:0]            lane;
		logic [3:0][OUT_W-1:0] res;
	} st_t;

	function automatic logic [63:0] qmag(input q_t x);
		logic [63:0] u;
		u = x;
		return x[63] ? (~u + 64'd1) : u;
	endfunction

	function automatic q_t from_mag(input logic neg, input logic [64:0] m);
		logic [63:0] c;
		c = (m > SAT_W) ? SAT_W[63:0] : m[63:0];
		return neg ? q_t'(~c + 64'd1) : q_t'(c);
	endfunction

	function automatic logic [64:0] sat_acc(input logic [64:0] r, input logic [63:0] b);
		logic [64:0] sum;
		sum = r + {1'b0, b};
		return (sum > SAT_W) ? SAT_W : sum;
	endfunction

	function automatic pp_t qmul_pp(input q_t a, input q_t b);
		logic [63:0] ua;
		logic [63:0] ub;
		pp_t r;
		ua = qmag(a);
		ub = qmag(b);
		r.neg = a[63] ^ b[63];
		r.hh  = 64'(ua[63:32]) * 64'(ub[63:32]);
		r.hl  = 64'(ua[63:32]) * 64'(ub[31:0]);
		r.lh  = 64'(ua[31:0]) * 64'(ub[63:32]);
		r.ll  = 64'(ua[31:0]) * 64'(ub[31:0]);
		return r;
	endfunction

	function automatic q_t qmul_fin(input pp_t p);
		logic [64:0] r;
		if (p.hh[63:31] != '0) begin
			r = SAT_W;
		end else begin
			r = {2'b00, p.hh[30:0], 32'd0};
			r = sat_acc(r, p.hl);
			r = sat_acc(r, p.lh);
			r = sat_acc(r, {32'd0, p.ll[63:32]});
		end
		return from_mag(p.neg, r);
	endfunction

	function automatic q_t qadd(input q_t a, input q_t b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > SAT_P)
			s = SAT_P;
		else if (s < SAT_N)
			s = SAT_N;
		return q_t'(s[63:0]);
	endfunction

	function automatic q_t qneg(input q_t a);
		return -a;
	endfunction

	// p * x, saturated, sign of x
	function automatic q_t lo_term(input q_t x, input logic [2:0] p);
		logic [66:0] prod;
		logic [64:0] m;
		prod = 67'(qmag(x)) * 67'(p);
		m = (prod > 67'(SAT_W)) ? SAT_W : prod[64:0];
		return from_mag(x[63], m);
	endfunction

	// p / k for k in 1..9 by reciprocal and one correction
	function automatic logic [31:0] div_step(input logic [31:0] p, input logic [3:0] k);
		logic [68:0] prod;
		logic [31:0] q0;
		logic [35:0] rem;
		prod = 69'(p) * 69'(RECIP[k]);
		q0 = prod[67:36];
		rem = 36'(p) - 36'(q0) * 36'(k);
		if (rem >= 36'(k))
			q0 = q0 + 32'd1;
		return q0;
	endfunction

	function automatic logic [2:0] pclamp(input logic [2:0] r);
		return (r > 3'(MAX_POWER)) ? 3'(MAX_POWER) : r;
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input q_t x);
		q_t c;
		if (x > OUT_MAX_Q)
			c = OUT_MAX_Q;
		else if (x < OUT_MIN_Q)
			c = OUT_MIN_Q;
		else
			c = x;
		return c[OUT_W-1:0];
	endfunction

endpackage

// ===== rtl/core/gaussian_orbital_value_gradient.sv =====
// Cartesian Gaussian primitive: value and xyz gradient per grid point.
// Depends on govg_pkg and gaussian_orbital_value_gradient_macros.svh.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------------
//  in      | in_valid / in_stall   | point_x, point_y, point_z (Q8.24)
//  out     | out_valid / out_stall | orbital_value, gradient_x/y/z (Q16.32, sat)
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (write only)
//
// One item per cycle through 40 register stages while the output is not held.
// The depth is set by the exp chain: 9 Horner steps of two stages each
// (product, then reciprocal divide) and 6 squaring stages.
// Every 64x64 fixed-point multiply is two stages: partial products, then sum.
// Reset clears valid bits, origin and powers and sets zeta and amplitude to 1.0; payload flops are not reset.
// A held output item freezes the whole pipe; in_stall follows it.
`include "gaussian_orbital_value_gradient_macros.svh"

module gaussian_orbital_value_gradient (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [govg_pkg::IN_W-1:0]       point_x,
	input  logic signed [govg_pkg::IN_W-1:0]       point_y,
	input  logic signed [govg_pkg::IN_W-1:0]       point_z,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [govg_pkg::OUT_W-1:0]      orbital_value,
	output logic signed [govg_pkg::OUT_W-1:0]      gradient_x,
	output logic signed [govg_pkg::OUT_W-1:0]      gradient_y,
	output logic signed [govg_pkg::OUT_W-1:0]      gradient_z,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [govg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [govg_pkg::CFG_W-1:0]             cfg_data
);
	import govg_pkg::*;

	// stage map
	localparam int S_D     = 1;   // displacement
	localparam int S_P2M   = 2;   // d^2 products
	localparam int S_P2F   = 3;
	localparam int S_P3M   = 4;   // also r^2 sum
	localparam int S_P3F   = 5;   // also zeta*r^2 products
	localparam int S_P4M   = 6;   // also t
	localparam int S_P4F   = 7;   // also exp argument
	localparam int S_P5M   = 8;
	localparam int S_P5F   = 9;
	localparam int S_BRM   = 10;  // bracket products, power select
	localparam int S_BRF   = 11;
	localparam int S_BRS   = 12;  // bracket sum
	localparam int S_H     = 8;   // first Horner stage
	localparam int S_SQ    = S_H + 2 * EXP_TERMS;
	localparam int S_COMM  = S_SQ + EXP_SQUARINGS;
	localparam int S_COMF  = S_COMM + 1;
	localparam int S_L0M   = S_COMF + 1;
	localparam int S_L0F   = S_L0M + 1;
	localparam int S_L1M   = S_L0F + 1;
	localparam int S_L1F   = S_L1M + 1;
	localparam int S_L2M   = S_L1F + 1;
	localparam int S_L2F   = S_L2M + 1;
	localparam int NST     = S_L2F + 1;   // output register

	// configuration
	logic [IN_W-1:0] origin_q [3];
	logic [47:0]     zeta_q;
	logic [47:0]     amp_q;
	logic [2:0]      power_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q[0] <= '0;
			origin_q[1] <= '0;
			origin_q[2] <= '0;
			zeta_q      <= 48'd1 << 24;
			amp_q       <= 48'd1 << 24;
			power_q[0]  <= '0;
			power_q[1]  <= '0;
			power_q[2]  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_ORIGIN_X:  origin_q[0] <= cfg_data[IN_W-1:0];
				REG_ORIGIN_Y:  origin_q[1] <= cfg_data[IN_W-1:0];
				REG_ORIGIN_Z:  origin_q[2] <= cfg_data[IN_W-1:0];
				REG_ZETA:      zeta_q      <= cfg_data[47:0];
				REG_AMPLITUDE: amp_q       <= cfg_data[47:0];
				REG_POWER_X:   power_q[0]  <= cfg_data[2:0];
				REG_POWER_Y:   power_q[1]  <= cfg_data[2:0];
				REG_POWER_Z:   power_q[2]  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// config seen in Q32.32
	q_t          zeta_x;
	q_t          two_zeta;
	q_t          amp_x;
	logic [2:0]  pow_sel [3];
	logic [2:0]  pow_up  [3];
	logic [2:0]  pow_dn  [3];
	logic [IN_W-1:0] pt [3];

	assign zeta_x   = q_t'({8'd0, zeta_q, 8'd0});
	assign two_zeta = q_t'({7'd0, zeta_q, 9'd0});
	assign amp_x    = q_t'({{8{amp_q[47]}}, amp_q, 8'd0});
	assign pt[0]    = point_x;
	assign pt[1]    = point_y;
	assign pt[2]    = point_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pow_sel[a] = pclamp(power_q[a]);
			pow_up[a]  = pow_sel[a] + 3'd1;
			pow_dn[a]  = (pow_sel[a] == 3'd0) ? 3'd0 : pow_sel[a] - 3'd1;
		end
	end

	// pipeline
	st_t          pipe_s [1:NST];
	logic [NST:1] vld_s;
	logic         advance;

	assign advance  = !vld_s[NST] || !out_stall;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (advance)
			vld_s <= {vld_s[NST-1:1], in_valid};
	end

	for (genvar g = 1; g <= NST; g++) begin : g_stage
		localparam int  HOFF      = g - S_H;
		localparam bit  IS_HORNER = (g >= S_H) && (g < S_SQ);
		localparam bit  IS_HMUL   = IS_HORNER && ((HOFF % 2) == 0);
		localparam int  K         = EXP_TERMS - HOFF / 2;
		localparam bit  IS_SQ     = (g >= S_SQ) && (g < S_COMM);

		st_t src;
		st_t nx;

		if (g == 1) begin : g_first
			assign src = '0;
		end else begin : g_next
			assign src = pipe_s[g-1];
		end

		always_comb begin
			logic signed [32:0] dif;
			logic [64:0]        hprod;
			logic [63:0]        sq;
			q_t                 e;
			q_t                 f;
			nx = src;
			dif = '0;
			hprod = '0;
			sq = '0;
			e = '0;
			f = '0;
			case (g)
				S_D: begin
					for (int a = 0; a < 3; a++) begin
						dif = {pt[a][IN_W-1], pt[a]} - {origin_q[a][IN_W-1], origin_q[a]};
						nx.d[a] = q_t'({{23{dif[32]}}, dif, 8'd0});
						nx.pw[a][0] = ONE_Q;
						nx.pw[a][1] = q_t'({{23{dif[32]}}, dif, 8'd0});
					end
				end
				S_P2M: for (int a = 0; a < 3; a++) nx.pp[a] = qmul_pp(src.d[a], src.d[a]);
				S_P2F: for (int a = 0; a < 3; a++) nx.pw[a][2] = qmul_fin(src.pp[a]);
				S_P3M: begin
					nx.r2 = qadd(qadd(src.pw[0][2], src.pw[1][2]), src.pw[2][2]);
					for (int a = 0; a < 3; a++) nx.pp[a] = qmul_pp(src.pw[a][2], src.d[a]);
				end
				S_P3F: begin
					for (int a = 0; a < 3; a++) nx.pw[a][3] = qmul_fin(src.pp[a]);
					nx.pp[3] = qmul_pp(zeta_x, src.r2);
				end
				S_P4M: begin
					nx.t = qmul_fin(src.pp[3]);
					for (int a = 0; a < 3; a++) nx.pp[a] = qmul_pp(src.pw[a][3], src.d[a]);
				end
				S_P4F: begin
					for (int a = 0; a < 3; a++) nx.pw[a][4] = qmul_fin(src.pp[a]);
					// from 24.0 up the result is zero
					nx.ez  = (src.t >= EXP_LIMIT);
					nx.s   = src.t[37:6];
					nx.acc = ONE_Q32;
				end
				S_P5M: for (int a = 0; a < 3; a++) nx.pp[a] = qmul_pp(src.pw[a][4], src.d[a]);
				S_P5F: for (int a = 0; a < 3; a++) nx.pw[a][5] = qmul_fin(src.pp[a]);
				S_BRM: begin
					for (int a = 0; a < 3; a++) begin
						nx.fac[a] = src.pw[a][pow_sel[a]];
						nx.pp[a]  = qmul_pp(two_zeta, src.pw[a][pow_up[a]]);
						nx.lo[a]  = lo_term(src.pw[a][pow_dn[a]], pow_sel[a]);
					end
				end
				S_BRF: for (int a = 0; a < 3; a++) nx.hi[a] = qmul_fin(src.pp[a]);
				S_BRS: for (int a = 0; a < 3; a++) nx.br[a] = qadd(src.lo[a], qneg(src.hi[a]));
				S_COMM: begin
					e = src.ez ? '0 : q_t'({31'd0, src.acc});
					nx.pp[0] = qmul_pp(amp_x, e);
				end
				S_COMF: nx.com = qmul_fin(src.pp[0]);
				S_L0M: begin
					nx.pp[0] = qmul_pp(src.com, src.fac[0]);
					nx.pp[1] = qmul_pp(src.com, src.br[0]);
					nx.pp[2] = nx.pp[0];
					nx.pp[3] = nx.pp[0];
				end
				S_L1M: begin
					for (int l = 0; l < 4; l++) begin
						f = (l == 2) ? src.br[1] : src.fac[1];
						nx.pp[l] = qmul_pp(src.lane[l], f);
					end
				end
				S_L2M: begin
					for (int l = 0; l < 4; l++) begin
						f = (l == 3) ? src.br[2] : src.fac[2];
						nx.pp[l] = qmul_pp(src.lane[l], f);
					end
				end
				S_L0F, S_L1F, S_L2F: for (int l = 0; l < 4; l++) nx.lane[l] = qmul_fin(src.pp[l]);
				NST: for (int l = 0; l < 4; l++) nx.res[l] = to_out(src.lane[l]);
				default: ;
			endcase
			// Horner: acc = 1 - (s*acc)/k, k from 9 down to 1
			if (IS_HMUL) begin
				hprod = 65'(src.s) * 65'(src.acc);
				nx.hp = hprod[63:32];
			end else if (IS_HORNER) begin
				nx.acc = ONE_Q32 - 33'(div_step(src.hp, 4'(K)));
			end
			if (IS_SQ && (src.acc < ONE_Q32)) begin
				sq = 64'(src.acc[31:0]) * 64'(src.acc[31:0]);
				nx.acc = {1'b0, sq[63:32]};
			end
		end

		always_ff @(posedge clk) begin
			if (advance)
				pipe_s[g] <= nx;
		end
	end

	assign out_valid     = vld_s[NST];
	assign orbital_value = pipe_s[NST].res[0];
	assign gradient_x    = pipe_s[NST].res[1];
	assign gradient_y    = pipe_s[NST].res[2];
	assign gradient_z    = pipe_s[NST].res[3];

	`GOVG_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, vld_s[1], "accepted item not in stage 1")
	`GOVG_ASSERT_NXT(a_hold_freezes, out_valid && out_stall, $stable(vld_s), "pipe moved while held")
	`GOVG_ASSERT_IMP(a_exp_bounded, vld_s[S_COMM-1], pipe_s[S_COMM-1].acc <= ONE_Q32, "exp above one")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for gaussian_orbital_value_gradient: grid points in,
// value and gradient out, checked against an in-bench fixed-point predictor.
// Depends on govg_pkg and the RTL of the block only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import govg_pkg::*;

	localparam int SETTINGS_COUNT = 10;
	localparam int ITEMS_PER_SETTING = 94;
	localparam int IDLE_LIMIT = 5000;
	// pipe is about 40 deep; give it some margin when draining
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic [OUT_W-1:0] value;
		logic [OUT_W-1:0] gx;
		logic [OUT_W-1:0] gy;
		logic [OUT_W-1:0] gz;
	} orbital_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		bit typed;
		orbital_t want;
	} point_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [IN_W-1:0] point_x;
	logic signed [IN_W-1:0] point_y;
	logic signed [IN_W-1:0] point_z;
	logic out_valid;
	logic out_stall;
	logic signed [OUT_W-1:0] orbital_value;
	logic signed [OUT_W-1:0] gradient_x;
	logic signed [OUT_W-1:0] gradient_y;
	logic signed [OUT_W-1:0] gradient_z;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// shadow of the block's registers, updated when a write is accepted
	logic signed [31:0] org_x, org_y, org_z;
	logic [47:0] zeta_reg;
	logic signed [47:0] amp_reg;
	logic [2:0] pow_x, pow_y, pow_z;

	orbital_t pending_q[$];
	int failures;
	int points_sent;
	int results_seen;
	int cfg_writes;
	int send_idle_pct;
	int stall_pct;
	int idle_count;

	gaussian_orbital_value_gradient uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.orbital_value(orbital_value), .gradient_x(gradient_x),
		.gradient_y(gradient_y), .gradient_z(gradient_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Fixed-point predictor. Q32.32 in 64 bits, magnitude saturating
	// at 2^63-1, products truncated toward zero.
	// ---------------------------------------------------------------
	function automatic q_t fx_mul(input q_t a, input q_t b);
		logic [63:0] ua, ub;
		logic [127:0] pr;
		logic neg;
		neg = a[63] ^ b[63];
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		// exact magnitude product, then drop 32 fraction bits
		pr = ({64'd0, ua} * {64'd0, ub}) >> 32;
		if (pr > 128'h7FFF_FFFF_FFFF_FFFF)
			pr = 128'h7FFF_FFFF_FFFF_FFFF;
		return neg ? -q_t'(pr[63:0]) : q_t'(pr[63:0]);
	endfunction

	function automatic q_t fx_add(input q_t a, input q_t b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
			s = 65'sh0_7FFF_FFFF_FFFF_FFFF;
		else if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF)
			s = -65'sh0_7FFF_FFFF_FFFF_FFFF;
		return s[63:0];
	endfunction

	function automatic q_t fx_pow(input q_t d, input int n);
		q_t acc;
		acc = 64'sh1_0000_0000;
		for (int i = 0; i < n; i++)
			acc = fx_mul(acc, d);
		return acc;
	endfunction

	// exp(-t): zero from 24.0 up, else degree-9 Horner on t/64, squared six times
	function automatic q_t gauss_decay(input q_t t);
		logic [127:0] s, acc, prod;
		if (t >= 64'sh18_0000_0000)
			return '0;
		if (t < 0)
			t = '0;
		s = 128'(t[63:0] >> 6);
		acc = 128'h1_0000_0000;
		for (int k = 9; k >= 1; k--) begin
			prod = (s * acc) >> 32;
			acc = 128'h1_0000_0000 - prod / k;
		end
		for (int k = 0; k < 6; k++) begin
			if (acc < 128'h1_0000_0000)
				acc = (acc * acc) >> 32;
		end
		return q_t'(acc[63:0]);
	endfunction

	// derivative factor of one axis: p*d^(p-1) - 2*zeta*d^(p+1)
	function automatic q_t axis_slope(input q_t d, input int p, input q_t two_zeta);
		q_t hi, lo;
		hi = fx_mul(two_zeta, fx_pow(d, p + 1));
		lo = '0;
		if (p > 0)
			lo = fx_mul(q_t'(p) <<< 32, fx_pow(d, p - 1));
		return fx_add(lo, -hi);
	endfunction

	function automatic logic [OUT_W-1:0] clamp_out(input q_t x);
		if (x > 64'sh0000_7FFF_FFFF_FFFF)
			x = 64'sh0000_7FFF_FFFF_FFFF;
		else if (x < 64'shFFFF_8000_0000_0000)
			x = 64'shFFFF_8000_0000_0000;
		return x[OUT_W-1:0];
	endfunction

	function automatic orbital_t orbital_at(input logic signed [31:0] px,
		input logic signed [31:0] py, input logic signed [31:0] pz);
		q_t d[3], pw[3], sl[3];
		int p[3];
		q_t r2, zeta, amp, common, two_zeta, acc;
		logic [2:0] raw[3];
		orbital_t o;
		d[0] = (q_t'(px) - q_t'(org_x)) * 256;
		d[1] = (q_t'(py) - q_t'(org_y)) * 256;
		d[2] = (q_t'(pz) - q_t'(org_z)) * 256;
		raw[0] = pow_x;
		raw[1] = pow_y;
		raw[2] = pow_z;
		zeta = q_t'({8'd0, zeta_reg, 8'd0});
		amp = q_t'(amp_reg) * 256;
		r2 = '0;
		for (int i = 0; i < 3; i++) begin
			r2 = fx_add(r2, fx_mul(d[i], d[i]));
			// powers above the maximum act as the maximum
			p[i] = (raw[i] > MAX_POWER) ? MAX_POWER : raw[i];
		end
		common = fx_mul(amp, gauss_decay(fx_mul(zeta, r2)));
		two_zeta = fx_mul(64'sh2_0000_0000, zeta);
		for (int i = 0; i < 3; i++) begin
			pw[i] = fx_pow(d[i], p[i]);
			sl[i] = axis_slope(d[i], p[i], two_zeta);
		end
		o.value = clamp_out(fx_mul(fx_mul(fx_mul(common, pw[0]), pw[1]), pw[2]));
		for (int j = 0; j < 3; j++) begin
			acc = common;
			for (int i = 0; i < 3; i++)
				acc = fx_mul(acc, (i == j) ? sl[i] : pw[i]);
			if (j == 0) o.gx = clamp_out(acc);
			else if (j == 1) o.gy = clamp_out(acc);
			else o.gz = clamp_out(acc);
		end
		return o;
	endfunction

	// ---------------------------------------------------------------
	// Result checking, receiver stalls and the watchdog
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input logic [OUT_W-1:0] want,
		input logic [OUT_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %h, got %h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		orbital_t w;
		if (!arst_n) begin
			out_stall <= 1'b0;
			idle_count <= 0;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_q.size() == 0) begin
					$error("result item with nothing expected");
					failures++;
				end else begin
					w = pending_q.pop_front();
					check_field("orbital_value", w.value, orbital_value);
					check_field("gradient_x", w.gx, gradient_x);
					check_field("gradient_y", w.gy, gradient_y);
					check_field("gradient_z", w.gz, gradient_z);
				end
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall)
				|| (cfg_valid && cfg_ready)) begin
				idle_count <= 0;
			end else if (idle_count >= IDLE_LIMIT) begin
				$display("FAIL gaussian_orbital_value_gradient");
				$finish;
			end else begin
				idle_count <= idle_count + 1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus tasks
	// ---------------------------------------------------------------

	// Drives one item and holds it until taken; valid is left high so the
	// next item can follow without a bubble.
	task automatic send_point(input point_row_t row);
		// each idle cycle drawn on its own, so the sender idles in the given share
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= row.x;
		point_y <= row.y;
		point_z <= row.z;
		do @(posedge clk); while (in_stall);
		// config is static while items flow, so predicting here is safe
		pending_q.insert(pending_q.size(),
			row.typed ? row.want : orbital_at(row.x, row.y, row.z));
		points_sent++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ORIGIN_X: org_x = v[31:0];
			REG_ORIGIN_Y: org_y = v[31:0];
			REG_ORIGIN_Z: org_z = v[31:0];
			REG_ZETA: zeta_reg = v;
			REG_AMPLITUDE: amp_reg = v;
			REG_POWER_X: pow_x = v[2:0];
			REG_POWER_Y: pow_y = v[2:0];
			default: pow_z = v[2:0];
		endcase
		cfg_writes++;
	endtask

	// Full register set, written only once the pipe is empty.
	task automatic load_setting(input logic [47:0] ox, input logic [47:0] oy,
		input logic [47:0] oz, input logic [47:0] z, input logic [47:0] a,
		input logic [47:0] px, input logic [47:0] py, input logic [47:0] pz);
		drain();
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_ZETA, z);
		write_reg(REG_AMPLITUDE, a);
		write_reg(REG_POWER_X, px);
		write_reg(REG_POWER_Y, py);
		write_reg(REG_POWER_Z, pz);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly points within a couple of bohr of the centre so the Gaussian is
	// not flushed to zero; the rest anywhere in the 32-bit range.
	function automatic point_row_t random_point();
		point_row_t r;
		r.typed = 1'b0;
		if ($urandom_range(99) < 70) begin
			r.x = org_x + ($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
			r.y = org_y + ($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
			r.z = org_z + ($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
		end else begin
			r.x = $urandom;
			r.y = $urandom;
			r.z = $urandom;
		end
		return r;
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	// Directed points under the reset setting (centre 0, zeta 1, amplitude 1,
	// all powers 0). Typed rows: at the centre the value is exactly 1.0 with a
	// flat gradient; at the corners of the range exp underflows to zero.
	point_row_t directed [12] = '{
		'{32'sh0, 32'sh0, 32'sh0, 1'b1,
			'{48'h0001_0000_0000, 48'h0, 48'h0, 48'h0}},
		'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1,
			'{48'h0, 48'h0, 48'h0, 48'h0}},
		'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1,
			'{48'h0, 48'h0, 48'h0, 48'h0}},
		'{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 1'b1,
			'{48'h0, 48'h0, 48'h0, 48'h0}},
		'{32'sh0100_0000, 32'sh0, 32'sh0, 1'b0, '{default: '0}},
		'{32'sh0, -32'sh0100_0000, 32'sh0, 1'b0, '{default: '0}},
		'{32'sh0, 32'sh0, 32'sh0080_0000, 1'b0, '{default: '0}},
		'{32'sh0000_0001, -32'sh0000_0001, 32'sh0000_0001, 1'b0, '{default: '0}},
		'{32'sh0300_0000, 32'sh0200_0000, -32'sh0100_0000, 1'b0, '{default: '0}},
		// exp bound: r2 just under and just over 24.0
		'{32'sh04E6_0000, 32'sh0, 32'sh0, 1'b0, '{default: '0}},
		'{32'sh04E6_3000, 32'sh0, 32'sh0, 1'b0, '{default: '0}},
		'{-32'sh0555_5555, 32'sh0AAA_AAAA, 32'sh5555_5555, 1'b0, '{default: '0}}
	};

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		point_row_t r;
		failures = 0;
		points_sent = 0;
		results_seen = 0;
		cfg_writes = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		in_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		// reset values of the register shadow
		org_x = '0;
		org_y = '0;
		org_z = '0;
		zeta_reg = 48'd1 << 24;
		amp_reg = 48'sd1 <<< 24;
		pow_x = '0;
		pow_y = '0;
		pow_z = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_point(directed[i]);

		for (int s = 0; s < SETTINGS_COUNT; s++) begin
			// idle mix rotates: none, sender gaps, receiver stalls, both lightly
			case (s % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 47; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 47; end
				default: begin send_idle_pct = 7; stall_pct = 7; end
			endcase
			case (s)
				// flat exponent, largest amplitude, top powers: saturates hard
				0: load_setting(48'h0, 48'h0, 48'h0, 48'h0, 48'h7FFF_FFFF_FFFF,
					48'd4, 48'd4, 48'd4);
				// most negative everything, largest exponent, powers past the cap
				1: load_setting(48'h8000_0000, 48'h8000_0000, 48'h8000_0000,
					48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000, 48'd7, 48'd6, 48'd5);
				// upper origin corner, tiny exponent, negative unit amplitude
				2: load_setting(48'h7FFF_FFFF, 48'h7FFF_FFFF, 48'h7FFF_FFFF,
					48'h1, 48'hFFFF_FF00_0000, 48'd1, 48'd2, 48'd3);
				default: load_setting(
					($urandom_range(3) == 0) ? {16'd0, $urandom} :
						48'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000),
					{16'd0, $urandom},
					48'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000),
					($urandom_range(3) == 0) ? rand48() :
						48'($urandom_range(0, 32'h0200_0000)),
					($urandom_range(3) == 0) ? rand48() :
						48'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000),
					48'($urandom_range(0, 7)), 48'($urandom_range(0, 7)),
					48'($urandom_range(0, 7)));
			endcase
			for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
				r = random_point();
				send_point(r);
			end
		end

		drain();
		$display("Covered %0d grid points and %0d register writes over %0d settings;",
			points_sent, cfg_writes, SETTINGS_COUNT + 1);
		$display("%0d result items compared, %0d mismatches.", results_seen, failures);
		if (failures == 0)
			$display("PASS gaussian_orbital_value_gradient");
		else
			$display("FAIL gaussian_orbital_value_gradient");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/govg_pkg.sv
rtl/core/gaussian_orbital_value_gradient.sv
tb/testbench.sv
